/* design/chs_pkg.sv */
// Package for the chained hash set engine: sizes, command and status codes.
// Used by every module of the design; depends on nothing.
package chs_pkg;
  localparam int unsigned BUCKETS_DEF = 1024;
  localparam int unsigned NODES_DEF = 1024;
  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;
  localparam logic [1:0] CMD_CLEAR = 2'd3;
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
endpackage

/* design/chs_ctrl.sv */
// Sequencer of the chained hash set engine: bucket, node and free-stack memories
// and the walk that reads, modifies and writes them back. Depends on chs_pkg.
module chs_ctrl #(
  parameter int unsigned BUCKETS = chs_pkg::BUCKETS_DEF,
  parameter int unsigned NODES = chs_pkg::NODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  logic [1:0]  req_cmd,
  input  logic [31:0] req_hash,
  input  logic [31:0] req_value,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [1:0]  res_status
);
  import chs_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = $clog2(NODES);
  localparam int CW = NW + 1;
  localparam logic [CW-1:0] NODES_C = CW'(NODES);
  localparam logic [BW-1:0] BLAST = BW'(BUCKETS - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_WIPE, S_HEAD, S_READ, S_CHECK, S_POP, S_DONE
  } state_t;

  state_t state;
  logic [1:0] cmd;
  logic [31:0] hsh, val;
  logic [BW-1:0] bkt, wipe_idx;
  logic [CW-1:0] fresh_count, free_count, cur, prev, steps;
  logic [1:0] status;

  logic used_mem [BUCKETS];
  logic [NW-1:0] head_mem [BUCKETS];
  logic [31:0] nhash_mem [NODES];
  logic [31:0] nval_mem [NODES];
  logic [CW-1:0] nnext_mem [NODES];
  logic [NW-1:0] free_mem [NODES];

  logic used_rd;
  logic [NW-1:0] head_rd, free_rd;
  logic [31:0] nhash_rd, nval_rd;
  logic [CW-1:0] nnext_rd;

  logic used_we, used_wd, head_we, node_we, next_we, free_we;
  logic [BW-1:0] used_wa, brd_a;
  logic [NW-1:0] head_wd, node_wa, next_wa, free_wa, nrd_a, frd_a;
  logic [CW-1:0] next_wd;
  logic match;

  assign req_ready = (state == S_IDLE) && !res_valid;
  assign res_status = status;
  assign match = (nhash_rd == hsh) && (nval_rd == val);

  always_comb begin
    used_we = 1'b0; used_wd = 1'b0; used_wa = bkt;
    head_we = 1'b0; head_wd = '0;
    node_we = 1'b0; node_wa = '0;
    next_we = 1'b0; next_wa = '0; next_wd = '0;
    free_we = 1'b0; free_wa = free_count[NW-1:0];
    brd_a = (state == S_IDLE) ? req_hash[BW-1:0] : bkt;
    nrd_a = cur[NW-1:0];
    frd_a = NW'(free_count - 1'b1);
    case (state)
      S_WIPE: begin
        used_we = 1'b1; used_wa = wipe_idx;
      end
      S_HEAD: begin
        if (cmd == CMD_INSERT) begin
          if (fresh_count < NODES_C) begin
            node_we = 1'b1; node_wa = fresh_count[NW-1:0];
          end
        end
      end
      S_POP: begin
        node_we = 1'b1; node_wa = free_rd;
      end
      S_CHECK: begin
        if (cmd == CMD_REMOVE && cur < NODES_C && steps < NODES_C && match) begin
          if (prev >= NODES_C) begin
            if (nnext_rd < NODES_C) begin
              head_we = 1'b1; head_wd = nnext_rd[NW-1:0];
            end else begin
              used_we = 1'b1;
            end
          end else begin
            next_we = 1'b1; next_wa = prev[NW-1:0]; next_wd = nnext_rd;
          end
          free_we = free_count < NODES_C;
        end
        nrd_a = nnext_rd[NW-1:0];
      end
      default: ;
    endcase
    if (node_we) begin
      used_we = 1'b1; used_wd = 1'b1;
      head_we = 1'b1; head_wd = node_wa;
      next_we = 1'b1; next_wa = node_wa;
      next_wd = used_rd ? {1'b0, head_rd} : NODES_C;
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_wa] <= used_wd;
    if (head_we) head_mem[bkt] <= head_wd;
    if (node_we) begin
      nhash_mem[node_wa] <= hsh;
      nval_mem[node_wa] <= val;
    end
    if (next_we) nnext_mem[next_wa] <= next_wd;
    if (free_we) free_mem[free_wa] <= cur[NW-1:0];
    used_rd <= used_mem[brd_a];
    head_rd <= head_mem[brd_a];
    nhash_rd <= nhash_mem[nrd_a];
    nval_rd <= nval_mem[nrd_a];
    nnext_rd <= nnext_mem[nrd_a];
    free_rd <= free_mem[frd_a];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      cmd <= CMD_INSERT;
      wipe_idx <= '0;
      fresh_count <= '0;
      free_count <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      case (state)
        S_WIPE: begin
          wipe_idx <= wipe_idx + 1'b1;
          if (wipe_idx == BLAST) begin
            if (cmd == CMD_CLEAR) begin
              status <= ST_OK;
              state <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (req_valid && req_ready) begin
            cmd <= req_cmd; hsh <= req_hash; val <= req_value;
            bkt <= req_hash[BW-1:0];
            if (req_cmd == CMD_CLEAR) begin
              fresh_count <= '0; free_count <= '0;
              wipe_idx <= '0;
              state <= S_WIPE;
            end else begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          if (cmd == CMD_INSERT) begin
            if (fresh_count < NODES_C) begin
              fresh_count <= fresh_count + 1'b1;
              status <= ST_OK; state <= S_DONE;
            end else if (free_count > 0) begin
              free_count <= free_count - 1'b1;
              state <= S_POP;
            end else begin
              status <= ST_FULL; state <= S_DONE;
            end
          end else if (!used_rd) begin
            status <= ST_MISS; state <= S_DONE;
          end else begin
            cur <= {1'b0, head_rd};
            prev <= NODES_C;
            steps <= '0;
            state <= S_READ;
          end
        end
        S_POP: begin
          status <= ST_OK; state <= S_DONE;
        end
        S_READ: state <= S_CHECK;
        S_CHECK: begin
          if (cur >= NODES_C || steps >= NODES_C) begin
            status <= ST_MISS; state <= S_DONE;
          end else if (match) begin
            if (cmd == CMD_REMOVE && free_count < NODES_C) free_count <= free_count + 1'b1;
            status <= ST_OK; state <= S_DONE;
          end else begin
            prev <= cur;
            cur <= nnext_rd;
            steps <= steps + 1'b1;
            state <= S_READ;
          end
        end
        S_DONE: begin
          res_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

/* design/chained_hash_set_engine_top.sv */
// Hash set with separate chaining over on-chip memories.
// Top level of the chained hash set engine; instantiates chs_ctrl, uses chs_pkg.
//
// Requests arrive on the in channel (cmd, key_hash, item_value) with valid and
// ready; each transaction yields one status transaction on the out channel.
// The bucket is the low bits of key_hash. Insert prepends a node, lookup and
// remove walk the chain for a node whose hash and value both match, clear
// empties every bucket and the pool.
// Lookup and remove do one memory read and compare per chain node visited;
// clear sweeps the bucket-used memory one entry a cycle.
// One transaction is in flight at a time; ready drops while a request is
// worked on and while a status waits, so a stalled receiver holds the input.
// After reset the same sweep of the bucket-used memory runs before in_ready rises.
module chained_hash_set_engine_top #(
  parameter int unsigned BUCKETS = chs_pkg::BUCKETS_DEF,
  parameter int unsigned NODES = chs_pkg::NODES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] key_hash,
  input  logic signed [31:0] item_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status
);
  import chs_pkg::*;

  chs_ctrl #(.BUCKETS(BUCKETS), .NODES(NODES)) u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(in_valid), .req_ready(in_ready),
    .req_cmd(cmd), .req_hash(key_hash), .req_value(item_value),
    .res_valid(out_valid), .res_ready(out_ready), .res_status(status)
  );
endmodule
